[src/cgps_pkg.sv]
// Shared types and constants for the correlated Gaussian path step block.
// Used by cgps_cell, cgps_mac and correlated_gaussian_path_step.
`default_nettype none
package cgps_pkg;

    localparam int TIME_W    = 4;
    localparam int IDX_W     = 3;
    localparam int VAL_W     = 32;
    localparam int OP_W      = 2;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 40;

    localparam logic [OP_W-1:0] OP_LOAD_ROOT  = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_START = 2'd1;
    localparam logic [OP_W-1:0] OP_INCREMENT  = 2'd2;

    localparam logic signed [63:0] Q_MAX = 64'sd2147483647;
    localparam logic signed [63:0] Q_MIN = -64'sd2147483648;

    // Control of one path cell
    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctrl_t;

    // Tag that travels beside a root entry through the multiply stage
    typedef struct packed {
        logic valid;
        logic apply;
    } mac_tag_t;

endpackage
`default_nettype wire

[src/cgps_cell.sv]
// One path component cell of the rotating component ring.
// Depends on cgps_pkg for the cell control struct.
`default_nettype none
module cgps_cell
    import cgps_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire cell_ctrl_t        ctrl,
    input  wire logic [VAL_W-1:0]  shift_in,
    input  wire logic [VAL_W-1:0]  load_value,
    output logic      [VAL_W-1:0]  value_out
);

    logic [VAL_W-1:0] value_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_reg <= '0;
        end else if (ctrl.load) begin
            value_reg <= load_value;
        end else if (ctrl.shift) begin
            value_reg <= shift_in;
        end
    end

    assign value_out = value_reg;

endmodule
`default_nettype wire

[src/cgps_mac.sv]
// Shared multiply and saturating add: root entry times increment, added to the ring head.
// Depends on cgps_pkg for the tag struct and saturation bounds.
`default_nettype none
module cgps_mac
    import cgps_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire mac_tag_t                 tag_in,
    input  wire logic signed [VAL_W-1:0]  root,
    input  wire logic signed [VAL_W-1:0]  z,
    input  wire logic signed [VAL_W-1:0]  head,
    output mac_tag_t                      tag_out,
    output logic signed [VAL_W-1:0]       sum_out
);

    logic signed [2*VAL_W-1:0] prod_reg;
    mac_tag_t                  tag_reg;
    logic signed [2*VAL_W-1:0] term;
    logic signed [2*VAL_W-1:0] wide_sum;
    logic signed [VAL_W-1:0]   sat_sum;

    always_ff @(posedge aclk) begin
        prod_reg <= root * z;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg <= '0;
        end else begin
            tag_reg <= tag_in;
        end
    end

    // Arithmetic shift floors toward minus infinity; the sum cannot overflow 64 bits
    always_comb begin
        term     = prod_reg >>> 16;
        wide_sum = {{VAL_W{head[VAL_W-1]}}, head} + term;
        if (wide_sum > Q_MAX) begin
            sat_sum = VAL_W'(Q_MAX);
        end else if (wide_sum < Q_MIN) begin
            sat_sum = VAL_W'(Q_MIN);
        end else begin
            sat_sum = wide_sum[VAL_W-1:0];
        end
    end

    assign tag_out = tag_reg;
    assign sum_out = tag_reg.apply ? sat_sum : head;

endmodule
`default_nettype wire

[src/correlated_gaussian_path_step.sv]
// Correlated Gaussian path step: top level with root memory, sequencer and cell ring.
// Depends on cgps_pkg, cgps_cell and cgps_mac.
//
// Usage:
//   Input stream (s_*): s_tuser carries the opcode, s_tdata the time index, row, column
//   and Q16.16 value. Opcode 0 writes a root entry, opcode 1 writes a start component,
//   opcode 2 supplies the normal increment for one column of step time_index.
//   Output stream (m_*): one request per component after the increment of the last
//   column, component 0 first, m_tlast on component DIM-1.
//   An increment sweeps its column: the sweep issues one root read per cycle to the
//   single memory read port, feeding one shared multiplier, and the component ring
//   advances one cell per cycle behind it. A final column then reports the
//   components one at a time, component 0 first, as the ring rotates through the
//   output register; a stalled output holds the report.
//   s_tready is low while an increment or a report is in progress; the block takes
//   the next item while the last result still waits in the output register.
//   Reset clears the path components to zero and empties the output register; the
//   root memory is not cleared and must be written before it is used.
//   When the receiver holds m_tready low during a report the ring holds and the result stays put.
`default_nettype none
module correlated_gaussian_path_step
    import cgps_pkg::*;
#(
    parameter int DIM   = 8,
    parameter int STEPS = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // time_index[3:0], row[6:4], col[9:7], value[41:10], zero pad
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // opcode[1:0]
    input  wire logic [OP_W-1:0]      s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // step_index[3:0], component[6:4], component_value[38:7], zero pad
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic                      m_tlast
);

    localparam int DEPTH = STEPS * DIM * DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = (DIM > 1) ? $clog2(DIM) : 1;
    localparam logic [CW-1:0] CNT_LAST = CW'(DIM - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_REPORT
    } state_t;

    // Input field split
    logic [OP_W-1:0]   s_opcode;
    logic [TIME_W-1:0] s_time_index;
    logic [IDX_W-1:0]  s_row;
    logic [IDX_W-1:0]  s_col;
    logic [VAL_W-1:0]  s_value;

    assign s_opcode     = s_tuser;
    assign s_time_index = s_tdata[3:0];
    assign s_row        = s_tdata[6:4];
    assign s_col        = s_tdata[9:7];
    assign s_value      = s_tdata[41:10];

    state_t             state_reg, state_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [TIME_W-1:0]  t_reg, t_next;
    logic [IDX_W-1:0]   col_reg, col_next;
    logic [VAL_W-1:0]   z_reg, z_next;
    mac_tag_t           p1_tag_reg, p1_tag_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [TIME_W-1:0]  m_step_reg, m_step_next;
    logic [IDX_W-1:0]   m_comp_reg, m_comp_next;
    logic [VAL_W-1:0]   m_value_reg, m_value_next;
    logic               m_last_reg, m_last_next;

    logic               in_fire;
    logic               report_fire;
    logic               root_we;
    logic [AW-1:0]      root_waddr;
    logic [AW-1:0]      root_raddr;
    logic [VAL_W-1:0]   root_rd_reg;
    logic [VAL_W-1:0]   root_mem [DEPTH];

    mac_tag_t           mac_tag;
    logic [VAL_W-1:0]   mac_sum;
    logic [VAL_W-1:0]   ring_in;
    logic [VAL_W-1:0]   cell_value [DIM];
    cell_ctrl_t         cell_ctrl  [DIM];

    assign s_tready    = (state_reg == ST_IDLE);
    assign in_fire     = s_tvalid && s_tready;
    assign report_fire = (state_reg == ST_REPORT) && (!m_tvalid_reg || m_tready);

    // Root memory: one write port at accept, one registered read port for the sweep
    assign root_we = in_fire && (s_opcode == OP_LOAD_ROOT) && (32'(s_time_index) < STEPS)
                     && (32'(s_row) < DIM) && (32'(s_col) < DIM);
    assign root_waddr = AW'((32'(s_time_index) * DIM + 32'(s_row)) * DIM + 32'(s_col));
    assign root_raddr = AW'((32'(t_reg) * DIM + 32'(cnt_reg)) * DIM + 32'(col_reg));

    always_ff @(posedge aclk) begin
        if (root_we) begin
            root_mem[root_waddr] <= s_value;
        end
    end

    always_ff @(posedge aclk) begin
        root_rd_reg <= root_mem[root_raddr];
    end

    cgps_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tag_in  (p1_tag_reg),
        .root    (root_rd_reg),
        .z       (z_reg),
        .head    (cell_value[0]),
        .tag_out (mac_tag),
        .sum_out (mac_sum)
    );

    // Ring: head is cell 0, updated head re-enters at the tail
    assign ring_in = mac_tag.valid ? mac_sum : cell_value[0];

    for (genvar k = 0; k < DIM; k++) begin : g_cell
        logic [VAL_W-1:0] shift_src;

        if (k == DIM - 1) begin : g_tail
            assign shift_src = ring_in;
        end else begin : g_mid
            assign shift_src = cell_value[k+1];
        end

        assign cell_ctrl[k].shift = mac_tag.valid || report_fire;
        assign cell_ctrl[k].load  = in_fire && (s_opcode == OP_LOAD_START)
                                    && (32'(s_row) == k);

        cgps_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (cell_ctrl[k]),
            .shift_in   (shift_src),
            .load_value (s_value),
            .value_out  (cell_value[k])
        );
    end

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        t_next        = t_reg;
        col_next      = col_reg;
        z_next        = z_reg;
        p1_tag_next   = '0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_step_next   = m_step_reg;
        m_comp_next   = m_comp_reg;
        m_value_next  = m_value_reg;
        m_last_next   = m_last_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_fire && (s_opcode == OP_INCREMENT) && (32'(s_time_index) < STEPS)
                    && (32'(s_col) < DIM)) begin
                    t_next     = s_time_index;
                    col_next   = s_col;
                    z_next     = s_value;
                    cnt_next   = '0;
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                // Issue one root read per component; only rows up to col apply
                p1_tag_next.valid = 1'b1;
                p1_tag_next.apply = (32'(cnt_reg) <= 32'(col_reg));
                if (cnt_reg == CNT_LAST) begin
                    cnt_next   = '0;
                    state_next = ST_DRAIN;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (!p1_tag_reg.valid && !mac_tag.valid) begin
                    state_next = (32'(col_reg) == DIM - 1) ? ST_REPORT : ST_IDLE;
                end
            end
            ST_REPORT: begin
                if (report_fire) begin
                    m_tvalid_next = 1'b1;
                    m_step_next   = t_reg;
                    m_comp_next   = IDX_W'(cnt_reg);
                    m_value_next  = cell_value[0];
                    m_last_next   = (cnt_reg == CNT_LAST);
                    if (cnt_reg == CNT_LAST) begin
                        cnt_next   = '0;
                        state_next = ST_IDLE;
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            p1_tag_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            p1_tag_reg   <= p1_tag_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        t_reg       <= t_next;
        col_reg     <= col_next;
        z_reg       <= z_next;
        m_step_reg  <= m_step_next;
        m_comp_reg  <= m_comp_next;
        m_value_reg <= m_value_next;
        m_last_reg  <= m_last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {1'b0, m_value_reg, m_comp_reg, m_step_reg};

`ifndef ASSERT_OFF
    a_mac_only_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        mac_tag.valid |-> (state_reg == ST_SWEEP || state_reg == ST_DRAIN))
        else $error("multiply stage active outside an increment");

    a_report_after_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_REPORT) |-> (!p1_tag_reg.valid && !mac_tag.valid))
        else $error("report started before the pipeline drained");

    a_last_ends_report: assert property (@(posedge aclk) disable iff (!aresetn)
        (report_fire && cnt_reg == CNT_LAST)
        |=> (state_reg == ST_IDLE && m_tvalid && m_tlast))
        else $error("final component did not close the report");
`endif

endmodule
`default_nettype wire
